/* src/ndc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ndc_pkg
// Shared types and constants of the number to digit characters block.
// ----------------------------------------------------------------------------
package ndc_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned MAX_DIGITS_DEF  = 16;
  localparam int unsigned RESULT_LIMIT    = 16;
  localparam int unsigned BCD_DIGITS      = 10;
  localparam int unsigned HEX_DIGITS      = 8;
  localparam int unsigned SRC_W           = 64;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h41;
  localparam logic [6:0] CHAR_PLUS  = 7'h2B;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [3:0] DEC_RADIX  = 4'd10;

  typedef enum logic [1:0] {
    KIND_UDEC = 2'd0,
    KIND_SDEC = 2'd1,
    KIND_HEX  = 2'd2,
    KIND_BIN  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_CONV   = 2'd1,
    ST_SIGN   = 2'd2,
    ST_DIGITS = 2'd3
  } state_e;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic is_decimal;
    logic is_signed;
    logic conv_last;
    logic n_zero;
    logic pos_zero;
    logic slot_free;
  } sts_t;

endpackage
`default_nettype wire

/* src/ndc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ndc_ctrl
// Sequencer: accept, decimal conversion, sign and digit emission.
// ----------------------------------------------------------------------------
module ndc_ctrl
  import ndc_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        if (!sts_i.is_decimal) begin
          state_d = ST_DIGITS;
        end else begin
          cmd_o.conv_step = 1'b1;
          if (sts_i.conv_last) begin
            state_d = sts_i.is_signed ? ST_SIGN : ST_DIGITS;
          end
        end
      end
      ST_SIGN: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = sts_i.n_zero ? ST_IDLE : ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (sts_i.n_zero) begin
          state_d = ST_IDLE;
        end else if (sts_i.slot_free) begin
          cmd_o.emit_digit = 1'b1;
          if (sts_i.pos_zero) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* src/ndc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ndc_datapath
// Request registers, shift-add-3 converter, digit select and output register.
// ----------------------------------------------------------------------------
module ndc_datapath
  import ndc_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned MAX_DIGITS  = MAX_DIGITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  wire  [1:0]  kind_i,
  input  wire  [31:0] value_i,
  input  wire  [4:0]  digit_count_i,
  input  wire  [2:0]  text_line_i,
  input  wire  [4:0]  start_column_i,
  input  wire         out_stall_i,
  output logic        out_valid_o,
  output logic [6:0]  ascii_char_o,
  output logic [2:0]  out_line_o,
  output logic [5:0]  out_column_o,
  output logic        last_o
);

  localparam int unsigned CAP   = (MAX_DIGITS > RESULT_LIMIT) ? RESULT_LIMIT : MAX_DIGITS;
  localparam int unsigned POS_W = $clog2(CAP);
  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned BCD_W = 4 * BCD_DIGITS;

  localparam logic [4:0] LIM_UDEC = 5'((BCD_DIGITS > CAP) ? CAP : BCD_DIGITS);
  localparam logic [4:0] LIM_SDEC = 5'((BCD_DIGITS > CAP - 1) ? CAP - 1 : BCD_DIGITS);
  localparam logic [4:0] LIM_HEX  = 5'((HEX_DIGITS > CAP) ? CAP : HEX_DIGITS);
  localparam logic [4:0] LIM_BIN  = 5'(CAP);

  kind_e                  kind_q;
  logic                   neg_q;
  logic [VALUE_WIDTH-1:0] sh_q, sh_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d, bcd_adj;
  logic [4:0]             n_q;
  logic [POS_W-1:0]       pos_q;
  logic [5:0]             col_q;
  logic [2:0]             line_q;
  logic [CNT_W-1:0]       cnt_q;

  logic                   out_valid_q;
  logic [6:0]             char_q;
  logic [2:0]             oline_q;
  logic [5:0]             ocol_q;
  logic                   last_q;

  kind_e                  kind_in;
  logic [VALUE_WIDTH-1:0] v_in, mag_in;
  logic                   neg_in;
  logic [4:0]             lim, n_sat;
  logic                   is_dec;
  logic [SRC_W-1:0]       nib_src;
  logic [3:0]             nib;
  logic [6:0]             dig_char;
  logic                   slot_free;

  // load-time decode
  always_comb begin
    kind_in = kind_e'(kind_i);
    v_in    = value_i[VALUE_WIDTH-1:0];
    neg_in  = (kind_in == KIND_SDEC) && v_in[VALUE_WIDTH-1];
    mag_in  = neg_in ? (VALUE_WIDTH'(0) - v_in) : v_in;
    case (kind_in)
      KIND_UDEC: lim = LIM_UDEC;
      KIND_SDEC: lim = LIM_SDEC;
      KIND_HEX:  lim = LIM_HEX;
      KIND_BIN:  lim = LIM_BIN;
      default:   lim = LIM_UDEC;
    endcase
    n_sat = (digit_count_i > lim) ? lim : digit_count_i;
  end

  // shift-add-3 step
  always_comb begin
    logic [3:0] dg;
    dg = '0;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      dg = bcd_q[4*k +: 4];
      bcd_adj[4*k +: 4] = (dg >= 4'd5) ? (dg + 4'd3) : dg;
    end
    bcd_d = {bcd_adj[BCD_W-2:0], sh_q[VALUE_WIDTH-1]};
    sh_d  = {sh_q[VALUE_WIDTH-2:0], 1'b0};
  end

  // digit select
  always_comb begin
    is_dec  = (kind_q == KIND_UDEC) || (kind_q == KIND_SDEC);
    nib_src = is_dec ? SRC_W'(bcd_q) : SRC_W'(sh_q);
    if (kind_q == KIND_BIN) begin
      nib = {3'b000, nib_src[6'(pos_q)]};
    end else begin
      nib = nib_src[6'({pos_q, 2'b00}) +: 4];
    end
    dig_char = (nib < DEC_RADIX) ? (CHAR_ZERO + 7'(nib))
                                 : (CHAR_A + 7'(nib) - 7'(DEC_RADIX));
  end

  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_in;
      neg_q  <= neg_in;
      sh_q   <= mag_in;
      bcd_q  <= '0;
      n_q    <= n_sat;
      pos_q  <= POS_W'(n_sat - 5'd1);
      col_q  <= {1'b0, start_column_i};
      line_q <= text_line_i;
      cnt_q  <= CNT_W'(VALUE_WIDTH);
    end else if (cmd_i.conv_step) begin
      sh_q  <= sh_d;
      bcd_q <= bcd_d;
      cnt_q <= cnt_q - 1'b1;
    end else if (cmd_i.emit_sign) begin
      col_q <= col_q + 6'd1;
    end else if (cmd_i.emit_digit) begin
      col_q <= col_q + 6'd1;
      pos_q <= pos_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_sign || cmd_i.emit_digit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      char_q  <= neg_q ? CHAR_MINUS : CHAR_PLUS;
      oline_q <= line_q;
      ocol_q  <= col_q;
      last_q  <= (n_q == 5'd0);
    end else if (cmd_i.emit_digit) begin
      char_q  <= dig_char;
      oline_q <= line_q;
      ocol_q  <= col_q;
      last_q  <= (pos_q == '0);
    end
  end

  always_comb begin
    sts_o.is_decimal = is_dec;
    sts_o.is_signed  = (kind_q == KIND_SDEC);
    sts_o.conv_last  = (cnt_q == CNT_W'(1));
    sts_o.n_zero     = (n_q == 5'd0);
    sts_o.pos_zero   = (pos_q == '0);
    sts_o.slot_free  = slot_free;
  end

  assign out_valid_o  = out_valid_q;
  assign ascii_char_o = char_q;
  assign out_line_o   = oline_q;
  assign out_column_o = ocol_q;
  assign last_o       = last_q;

endmodule
`default_nettype wire

/* src/number_to_digit_chars.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// number_to_digit_chars
// Renders one number as fixed-width ASCII characters, most significant first.
//
// The input channel takes one request: kind, value, digit count, text line
// and start column. The output channel returns one item per character with
// its line and column; the final character of a request has last set.
// An item is taken at a clock edge where valid is high and stall is low.
// Steps per request, with n the saturated digit count:
//   decimal modes: accept, shift-add-3 conversion of all VALUE_WIDTH bits,
//                  the sign in signed mode, then n digit emits
//   hex and binary: accept, dispatch, then n digit emits
// Each character enters the output register in the cycle after its emit.
// A receiver stall holds the output register and pauses emission; the next
// request is taken once the last character sits in the output register.
// Reset clears the sequencer and the output valid; no state spans requests.
// ----------------------------------------------------------------------------
module number_to_digit_chars
  import ndc_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned MAX_DIGITS  = MAX_DIGITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  kind_i,
  input  wire  [31:0] value_i,
  input  wire  [4:0]  digit_count_i,
  input  wire  [2:0]  text_line_i,
  input  wire  [4:0]  start_column_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [6:0]  ascii_char_o,
  output logic [2:0]  out_line_o,
  output logic [5:0]  out_column_o,
  output logic        last_o
);

  cmd_t cmd;
  sts_t sts;

  ndc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ndc_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_i         (kind_i),
    .value_i        (value_i),
    .digit_count_i  (digit_count_i),
    .text_line_i    (text_line_i),
    .start_column_i (start_column_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .ascii_char_o   (ascii_char_o),
    .out_line_o     (out_line_o),
    .out_column_o   (out_column_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire

/* src/ndc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ndc_checker
// Port-level checks of the number to digit characters block.
// ----------------------------------------------------------------------------
module ndc_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire  [6:0] ascii_char_o,
  input wire  [2:0] out_line_o,
  input wire  [5:0] out_column_o,
  input wire        last_o
);

  // stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ascii_char_o)
      && $stable(out_line_o) && $stable(out_column_o) && $stable(last_o))
    else $error("stalled output item changed");

  // busy right after a request is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken twice in a row");

  // no new request while the current one has characters left
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("request accepted before last character");

  // characters only from sign, digit or hex letter range
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ascii_char_o == 7'h2B) || (ascii_char_o == 7'h2D)
      || ((ascii_char_o >= 7'h30) && (ascii_char_o <= 7'h39))
      || ((ascii_char_o >= 7'h41) && (ascii_char_o <= 7'h46)))
    else $error("unexpected output character");

endmodule

bind number_to_digit_chars ndc_checker u_ndc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .ascii_char_o (ascii_char_o),
  .out_line_o   (out_line_o),
  .out_column_o (out_column_o),
  .last_o       (last_o)
);
`default_nettype wire
